### src/smtq_pkg.sv
// ============================================================================
// smtq_pkg
// Shared types, constants and helpers of the sorted multi-timer queue.
// ============================================================================
package smtq_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int TIME_BITS   = 48;
	localparam int PERIOD_BITS = 32;
	localparam int SLOT_W      = $clog2(NUM_TIMERS);

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [PERIOD_BITS-1:0] PERIOD_NONE = '0;
	localparam logic [PERIOD_BITS-1:0] PERIOD_ONE  = PERIOD_BITS'(1);

	// one queue entry as held by a cell
	typedef struct packed {
		logic                   valid;
		logic                   flag;     // due on the tick being served
		logic [SLOT_W-1:0]      slot;
		logic [TIME_BITS-1:0]   deadline;
		logic [PERIOD_BITS-1:0] period;
	} entry_t;

	localparam entry_t ENTRY_EMPTY = '0;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_REMOVE,
		OP_INSERT,
		OP_MARK
	} op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		op_t                  op;
		logic [SLOT_W-1:0]    slot;
		entry_t               entry;
		logic [TIME_BITS-1:0] now;
	} cmd_t;

	// handed from a cell to its successor
	typedef struct packed {
		logic shift;  // removal point is at or before this cell
		logic le;     // this cell sorts at or before the new entry
	} link_t;

	localparam link_t LINK_HEAD = '{shift: 1'b0, le: 1'b1};

	// add with saturation at the top of the time range
	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0]   a,
		input logic [PERIOD_BITS-1:0] b
	);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + (TIME_BITS+1)'(b);
		if (sum[TIME_BITS]) begin
			return '1;
		end
		return sum[TIME_BITS-1:0];
	endfunction

endpackage

### src/sorted_multi_timer_queue.sv
// ============================================================================
// sorted_multi_timer_queue
// Bank of timer slots kept in deadline order in a chain of shifting cells.
// ============================================================================
//
//   channel   handshake               payload
//   item      item_valid/item_stall   kind, timer_id, delay_ms, periodic
//   fire      fire_valid/fire_stall   fired_timer, last
//
// Start: remove, then insert. Stop: remove. Tick: mark, then remove each due
// head, re-inserting it if periodic. Unless a fire stall holds it, the chain
// does one remove, one insert or one mark per cycle; each start, stop and tick
// goes through it in turn; item_stall is high until the chain is back to idle.
// Reset clears the counter, the chain and the output register at once.
// A finished firing waits in the output register while the block goes on.
// ============================================================================
module sorted_multi_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  timer_id,
	input  logic [31:0] delay_ms,
	input  logic        periodic,
	output logic        fire_valid,
	input  logic        fire_stall,
	output logic [3:0]  fired_timer,
	output logic        last
);
	import smtq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REMOVE = 5'b00010,
		S_INSERT = 5'b00100,
		S_MARK   = 5'b01000,
		S_FIRE   = 5'b10000
	} state_t;

	state_t                state_q;
	logic [TIME_BITS-1:0]  now_q;
	logic                  ins_pend_q;   // insert follows the removal
	logic                  ret_fire_q;   // go back to firing afterwards
	logic [SLOT_W-1:0]     rem_id_q;
	entry_t                new_q;
	logic                  fire_valid_q;
	logic [3:0]            fired_q;
	logic                  last_q;

	entry_t cells [NUM_TIMERS];
	link_t  links [NUM_TIMERS+1];
	cmd_t   cmd;

	logic                   accept;
	logic                   id_ok;
	logic [PERIOD_BITS-1:0] start_period;
	entry_t                 start_entry;
	entry_t                 head;
	logic                   head_due;
	logic                   next_due;
	logic                   out_free;
	logic                   fire_load;
	logic [TIME_BITS-1:0]   refire_sum;
	entry_t                 refire_entry;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !fire_valid_q || !fire_stall;

	assign fire_valid  = fire_valid_q;
	assign fired_timer = fired_q;
	assign last        = last_q;

	// Chain of cells: the head is the earliest deadline, ties in arming order.
	assign links[0] = LINK_HEAD;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		if (i == 0) begin : g_first
			assign prev_e = ENTRY_EMPTY;
		end else begin : g_mid
			assign prev_e = cells[i-1];
		end
		if (i == NUM_TIMERS-1) begin : g_last
			assign next_e = ENTRY_EMPTY;
		end else begin : g_inner
			assign next_e = cells[i+1];
		end
		smtq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.link_in    (links[i]),
			.entry      (cells[i]),
			.link_out   (links[i+1])
		);
	end

	always_comb begin
		cmd.slot  = rem_id_q;
		cmd.entry = new_q;
		cmd.now   = now_q;
		unique case (state_q)
			S_REMOVE: cmd.op = OP_REMOVE;
			S_INSERT: cmd.op = OP_INSERT;
			S_MARK:   cmd.op = OP_MARK;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// Start: a periodic period is the delay, forced to one when the delay is zero.
	always_comb begin
		id_ok = (int'(timer_id) < NUM_TIMERS);
		if (!periodic) begin
			start_period = PERIOD_NONE;
		end else if (delay_ms == '0) begin
			start_period = PERIOD_ONE;
		end else begin
			start_period = delay_ms;
		end
		start_entry = '{valid: 1'b1, flag: 1'b0, slot: SLOT_W'(timer_id),
			deadline: sat_add(now_q, delay_ms), period: start_period};
	end

	// Firing: flagged entries form a prefix, and a re-armed entry lands behind
	// every remaining flagged one, so it cannot fire twice on one tick.
	always_comb begin
		head       = cells[0];
		head_due   = head.valid && head.flag;
		next_due   = cells[1].valid && cells[1].flag;
		fire_load  = (state_q == S_FIRE) && head_due && out_free;
		refire_sum = sat_add(head.deadline, head.period);
		refire_entry = '{valid: 1'b1, flag: 1'b0, slot: head.slot,
			deadline: (refire_sum < now_q) ? now_q : refire_sum,
			period: head.period};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			now_q      <= '0;
			ins_pend_q <= 1'b0;
			ret_fire_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority case (kind)
							KIND_START: begin
								if (id_ok) begin
									ins_pend_q <= 1'b1;
									ret_fire_q <= 1'b0;
									state_q    <= S_REMOVE;
								end
							end
							KIND_STOP: begin
								if (id_ok) begin
									ins_pend_q <= 1'b0;
									ret_fire_q <= 1'b0;
									state_q    <= S_REMOVE;
								end
							end
							KIND_TICK: begin
								now_q   <= now_q + TIME_BITS'(1);
								state_q <= S_MARK;
							end
							default: begin
							end
						endcase
					end
				end
				S_REMOVE: begin
					if (ins_pend_q) begin
						state_q <= S_INSERT;
					end else if (ret_fire_q) begin
						state_q <= S_FIRE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_INSERT: begin
					state_q <= ret_fire_q ? S_FIRE : S_IDLE;
				end
				S_MARK: begin
					state_q <= S_FIRE;
				end
				S_FIRE: begin
					if (!head_due) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						// drop the head, re-arm it behind the due ones if periodic
						ins_pend_q <= (head.period != PERIOD_NONE);
						ret_fire_q <= 1'b1;
						state_q    <= S_REMOVE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command payload registers: hold the slot and the entry for the chain.
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_id_q <= SLOT_W'(timer_id);
			new_q    <= start_entry;
		end else if (fire_load) begin
			rem_id_q <= head.slot;
			new_q    <= refire_entry;
		end
	end

	// Output register: advance when empty or when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_valid_q <= 1'b0;
		end else if (out_free) begin
			fire_valid_q <= fire_load;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_load) begin
			fired_q <= 4'(head.slot);
			last_q  <= !next_due;
		end
	end

endmodule

### src/smtq_cell.sv
// ============================================================================
// smtq_cell
// One position of the sorted timer chain; shifts with its neighbors.
// ============================================================================
module smtq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  smtq_pkg::cmd_t  cmd,
	input  smtq_pkg::entry_t prev_entry,
	input  smtq_pkg::entry_t next_entry,
	input  smtq_pkg::link_t link_in,
	output smtq_pkg::entry_t entry,
	output smtq_pkg::link_t link_out
);
	import smtq_pkg::*;

	logic                   valid_q;
	logic                   flag_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [TIME_BITS-1:0]   deadline_q;
	logic [PERIOD_BITS-1:0] period_q;

	logic   hit;
	logic   shift;
	logic   le;
	logic   load;
	entry_t nxt;

	always_comb begin
		entry = '{valid: valid_q, flag: flag_q, slot: slot_q,
			deadline: deadline_q, period: period_q};
		hit   = valid_q && (slot_q == cmd.slot);
		shift = link_in.shift || hit;
		le    = valid_q && (deadline_q <= cmd.entry.deadline);
		link_out = '{shift: shift, le: le};
		load = 1'b0;
		nxt  = entry;
		unique case (cmd.op)
			OP_REMOVE: begin
				// close the gap: pull the successor up
				if (shift) begin
					load = 1'b1;
					nxt  = next_entry;
				end
			end
			OP_INSERT: begin
				// open a gap after every entry that sorts at or before the new one
				if (!le) begin
					load = 1'b1;
					nxt  = link_in.le ? cmd.entry : prev_entry;
				end
			end
			OP_MARK: begin
				load     = 1'b1;
				nxt.flag = valid_q && (deadline_q <= cmd.now);
			end
			OP_NONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flag_q  <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
			flag_q  <= nxt.flag;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q     <= nxt.slot;
			deadline_q <= nxt.deadline;
			period_q   <= nxt.period;
		end
	end

endmodule

### dv/sorted_multi_timer_queue_test.sv
// ============================================================================
// sorted_multi_timer_queue_test
// Self-checking bench: a directed script, then three phases of random
// start/stop/tick traffic. A local copy of the timer bank predicts every
// firing, and each firing leaving the block is checked against it in order.
// ============================================================================
`timescale 1ns / 100ps

module sorted_multi_timer_queue_test;
	import smtq_pkg::*;

	localparam int          LIMIT_CYCLES = 600_000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          TAIL_CYCLES  = 200;
	localparam int          PHASE_ITEMS  = 95;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;

	// how the directed script checks a row
	typedef enum logic [1:0] {
		CHECK_MODEL,  // firings come from the timer bank copy
		CHECK_NONE,   // no firing at all
		CHECK_ONE     // exactly the one firing typed into the row
	} row_check_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              last;
	} firing_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        id;
		logic [31:0]       delay;
		logic              per;
		row_check_t        check;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  kind;
	logic [3:0]  timer_id;
	logic [31:0] delay_ms;
	logic        periodic;
	logic        fire_valid;
	logic        fire_stall;
	logic [3:0]  fired_timer;
	logic        last;

	// bench copy of the timer bank
	logic [TIME_BITS-1:0]   now_ms;
	logic                   slot_live [NUM_TIMERS];
	logic [TIME_BITS-1:0]   slot_due [NUM_TIMERS];
	logic [PERIOD_BITS-1:0] slot_period [NUM_TIMERS];
	int                     slot_rank [NUM_TIMERS];

	firing_t     tick_firings[$];     // firings of the latest transaction
	firing_t     pending_firings[$];  // firings still owed by the block
	firing_t     head_firing;
	script_row_t script_rows[$];

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	bit hold_off;
	int hold_count;
	int mismatches;
	int firings_seen;
	int cycle_count;

	sorted_multi_timer_queue u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.timer_id   (timer_id),
		.delay_ms   (delay_ms),
		.periodic   (periodic),
		.fire_valid (fire_valid),
		.fire_stall (fire_stall),
		.fired_timer(fired_timer),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Timer bank copy
	// ------------------------------------------------------------------------

	// deadlines stick at the top of the time range instead of wrapping
	function automatic logic [TIME_BITS-1:0] clamp_add(
		input logic [TIME_BITS-1:0]   base,
		input logic [PERIOD_BITS-1:0] step
	);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, base} + (TIME_BITS+1)'(step);
		return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	endfunction

	// disarm a slot and close the gap it leaves in arming order
	task automatic drop_slot(input int s);
		int j;
		if (slot_live[s]) begin
			for (j = 0; j < NUM_TIMERS; j++) begin
				if (slot_live[j] && slot_rank[j] > slot_rank[s]) begin
					slot_rank[j]--;
				end
			end
		end
		slot_live[s] = 1'b0;
		slot_rank[s] = 0;
	endtask

	// arm a slot as the most recently armed one
	task automatic place_slot(input int s, input logic [TIME_BITS-1:0] due);
		int j;
		int armed_cnt;
		drop_slot(s);
		armed_cnt = 0;
		for (j = 0; j < NUM_TIMERS; j++) begin
			if (slot_live[j]) begin
				armed_cnt++;
			end
		end
		slot_rank[s] = armed_cnt;
		slot_live[s] = 1'b1;
		slot_due[s]  = due;
	endtask

	// apply one transaction to the bank; firings land in tick_firings
	task automatic step_timer_bank(
		input logic [1:0]  k,
		input logic [3:0]  id,
		input logic [31:0] d,
		input logic        p
	);
		int                   j;
		int                   n;
		int                   best;
		int                   s;
		bit                   searching;
		bit                   picked [NUM_TIMERS];
		int                   fire_order [NUM_TIMERS];
		logic [TIME_BITS-1:0] next_due;
		tick_firings.delete();
		case (k)
			KIND_START: begin
				if (!p) begin
					slot_period[id] = PERIOD_NONE;
				end else begin
					slot_period[id] = (d == '0) ? PERIOD_ONE : d;
				end
				place_slot(int'(id), clamp_add(now_ms, d));
			end
			KIND_STOP: begin
				drop_slot(int'(id));
			end
			KIND_TICK: begin
				now_ms = now_ms + 1'b1;
				n = 0;
				for (j = 0; j < NUM_TIMERS; j++) begin
					picked[j] = 1'b0;
				end
				// pick due slots by deadline, ties by arming order
				searching = 1'b1;
				while (searching) begin
					best = -1;
					for (j = 0; j < NUM_TIMERS; j++) begin
						if (slot_live[j] && !picked[j] && slot_due[j] <= now_ms) begin
							if (best < 0 || slot_due[j] < slot_due[best] ||
							    (slot_due[j] == slot_due[best] &&
							     slot_rank[j] < slot_rank[best])) begin
								best = j;
							end
						end
					end
					if (best < 0) begin
						searching = 1'b0;
					end else begin
						picked[best]  = 1'b1;
						fire_order[n] = best;
						n++;
					end
				end
				// re-arm in firing order; a slot fires once per tick at most
				for (j = 0; j < n; j++) begin
					s = fire_order[j];
					tick_firings.push_back('{slot: SLOT_W'(s), last: (j == n - 1)});
					if (slot_period[s] != PERIOD_NONE) begin
						next_due = clamp_add(slot_due[s], slot_period[s]);
						if (next_due < now_ms) begin
							next_due = now_ms;
						end
						place_slot(s, next_due);
					end else begin
						drop_slot(s);
					end
				end
			end
			default: begin
				// unused kind: nothing changes
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 100) begin
			$display("[%0t] mismatch on firing %0d: %s got %0d expected %0d",
			         $realtime, firings_seen, what, got, want);
		end
	endtask

	// Compare each accepted firing with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && fire_valid && !fire_stall) begin
			if (pending_firings.size() == 0) begin
				report_mismatch("firing with nothing due, fired_timer", int'(fired_timer), -1);
			end else begin
				head_firing = pending_firings.pop_front();
				if (fired_timer !== head_firing.slot) begin
					report_mismatch("fired_timer", int'(fired_timer), int'(head_firing.slot));
				end
				if (last !== head_firing.last) begin
					report_mismatch("last", int'(last), int'(head_firing.last));
				end
			end
			firings_seen++;
		end
	end

	// ------------------------------------------------------------------------
	// Fire side: random stall, or a long hold-off when asked for
	// ------------------------------------------------------------------------

	initial begin
		fire_stall = 1'b0;
		forever begin
			@(negedge clk);
			fire_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Hold the fire side off for a fixed stretch, counted here, so the chain
	// backs up and item_stall rises while the sender keeps offering.
	initial begin
		hold_off = 1'b0;
		forever begin
			wait (hold_req);
			hold_req   = 1'b0;
			hold_off   = 1'b1;
			hold_count = 0;
			while (hold_count < HOLD_CYCLES) begin
				@(posedge clk);
				hold_count++;
			end
			hold_off = 1'b0;
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** sorted_multi_timer_queue: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Item side
	// ------------------------------------------------------------------------

	// Offer one transaction, wait until it is taken, then record what it owes.
	task automatic push_transaction(
		input logic [1:0]        k,
		input logic [3:0]        id,
		input logic [31:0]       d,
		input logic              p,
		input row_check_t        check,
		input logic [SLOT_W-1:0] typed_slot,
		input logic              typed_last
	);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		timer_id   <= id;
		delay_ms   <= d;
		periodic   <= p;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		step_timer_bank(k, id, d, p);
		case (check)
			CHECK_MODEL: begin
				foreach (tick_firings[i]) begin
					pending_firings.push_back(tick_firings[i]);
				end
			end
			CHECK_ONE: begin
				pending_firings.push_back('{slot: typed_slot, last: typed_last});
			end
			default: begin
			end
		endcase
	endtask

	// Drop valid and hold until every owed firing has come out.
	task automatic settle_firings();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_firings.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic add_row(
		input logic [1:0]        k,
		input logic [3:0]        id,
		input logic [31:0]       d,
		input logic              p,
		input row_check_t        check,
		input logic [SLOT_W-1:0] typed_slot,
		input logic              typed_last
	);
		script_rows.push_back('{kind: k, id: id, delay: d, per: p, check: check,
		                        slot: typed_slot, last: typed_last});
	endtask

	// Random traffic: mostly short delays so slots keep firing, some full
	// 32-bit delays that park a slot for good. Unused kinds do not count.
	task automatic random_phase(input int count, input int hold_at);
		int          done;
		int          pick;
		int          span;
		logic [1:0]  k;
		logic [3:0]  id;
		logic [31:0] d;
		logic        p;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(99);
			span = $urandom_range(9);
			id   = 4'($urandom_range(15));
			p    = 1'($urandom_range(1));
			if (span < 5) begin
				d = $urandom_range(6);
			end else if (span < 8) begin
				d = $urandom_range(40, 7);
			end else begin
				d = $urandom;
			end
			if (pick < 2) begin
				k = KIND_UNUSED;
			end else if (pick < 40) begin
				k = KIND_START;
			end else if (pick < 52) begin
				k = KIND_STOP;
			end else begin
				k = KIND_TICK;
			end
			if (done == hold_at && k != KIND_UNUSED) begin
				hold_req = 1'b1;
			end
			push_transaction(k, id, d, p, CHECK_MODEL, '0, 1'b0);
			if (k != KIND_UNUSED) begin
				done++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		kind           = KIND_START;
		timer_id       = '0;
		delay_ms       = '0;
		periodic       = 1'b0;
		hold_req       = 1'b0;
		mismatches     = 0;
		firings_seen   = 0;
		send_idle_pct  = 30;
		recv_stall_pct = 76;

		// bank copy starts out as after reset
		now_ms = '0;
		for (int j = 0; j < NUM_TIMERS; j++) begin
			slot_live[j]   = 1'b0;
			slot_due[j]    = '0;
			slot_period[j] = PERIOD_NONE;
			slot_rank[j]   = 0;
		end

		// Directed script. Starts and stops never fire; the first one-shot
		// with zero delay fires alone on the next tick.
		add_row(KIND_TICK,   4'd0,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd15, 32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_TICK,   4'd0,  32'd0,          1'b0, CHECK_ONE,   4'd15, 1'b1);
		// full delay, periodic: parked far in the future
		add_row(KIND_START,  4'd0,  32'hFFFF_FFFF,  1'b1, CHECK_NONE,  '0, 1'b0);
		// periodic with zero delay runs at period one
		add_row(KIND_START,  4'd5,  32'd0,          1'b1, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd6,  32'd1,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd7,  32'd1,          1'b1, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_TICK,   4'd0,  32'd0,          1'b0, CHECK_MODEL, '0, 1'b0);
		// equal deadlines, then a restart that moves slot 6 behind slot 8
		add_row(KIND_START,  4'd6,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd8,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd6,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		// stop of an idle slot, then of an armed one
		add_row(KIND_STOP,   4'd9,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_STOP,   4'd7,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_TICK,   4'd0,  32'd0,          1'b0, CHECK_MODEL, '0, 1'b0);
		// unused kind with every other field at its top: ignored
		add_row(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF,  1'b1, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd10, 32'd5,          1'b1, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd3,  32'd2,          1'b1, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_STOP,   4'd0,  32'd0,          1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd1,  32'h8000_0000,  1'b0, CHECK_NONE,  '0, 1'b0);
		add_row(KIND_START,  4'd2,  32'h5555_5555,  1'b1, CHECK_NONE,  '0, 1'b0);
		for (int r = 0; r < 5; r++) begin
			add_row(KIND_TICK, 4'd0, 32'd0, 1'b0, CHECK_MODEL, '0, 1'b0);
		end

		// hold reset, then release it on a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script_rows[r]) begin
			push_transaction(script_rows[r].kind, script_rows[r].id, script_rows[r].delay,
			                 script_rows[r].per, script_rows[r].check,
			                 script_rows[r].slot, script_rows[r].last);
		end

		// phase one: sender idles a little, fire side stalls a lot
		random_phase(PHASE_ITEMS, -1);
		settle_firings();

		// phase two: the other way round
		send_idle_pct  = 76;
		recv_stall_pct = 30;
		random_phase(PHASE_ITEMS, -1);
		settle_firings();

		// phase three: no idling, with one long hold-off on the fire side
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_phase(PHASE_ITEMS, 20);
		settle_firings();

		// catch any stray firing after the last one owed
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("** sorted_multi_timer_queue: PASSED **");
		end else begin
			$display("** sorted_multi_timer_queue: FAILED **");
		end
		$finish;
	end

endmodule
